[rtl/iptv_pkg.sv]
// iptv_pkg: shared types, constants and the character classifier for the
// address text validator. No dependencies.
package iptv_pkg;

    // result codes
    typedef enum logic [1:0] {
        KIND_V4      = 2'd0,
        KIND_V6      = 2'd1,
        KIND_UNKNOWN = 2'd2
    } t_ip_kind;

    // section limits and counts
    localparam int unsigned DEC_MAX      = 255;
    localparam int unsigned HEX_MAX      = 'hffff;
    localparam int unsigned DEC_SECTIONS = 4;
    localparam int unsigned HEX_SECTIONS = 8;
    localparam int unsigned DEC_BASE     = 10;
    localparam int unsigned HEX_BASE     = 16;

    // default depth of the queue between front and back
    localparam int unsigned IPTV_QUEUE_DEPTH = 4;

    // classified character, handed from front to back
    typedef struct packed {
        logic       is_dot;
        logic       is_colon;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
        logic       last;
    } t_iptv_cls;

    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // classify one byte of text
    function automatic t_iptv_cls iptv_classify(input logic [7:0] c, input logic last);
        t_iptv_cls r;
        logic [7:0] d;
        r        = '0;
        d        = 8'd0;
        r.last   = last;
        r.is_dot   = (c == CH_DOT);
        r.is_colon = (c == CH_COLON);
        if (c >= CH_0 && c <= CH_9) begin
            d        = c - CH_0;
            r.is_dec = 1'b1;
            r.is_hex = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
            d        = c - CH_LA + 8'd10;
            r.is_hex = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            d        = c - CH_UA + 8'd10;
            r.is_hex = 1'b1;
        end
        r.digit = d[3:0];
        return r;
    endfunction

endpackage

[rtl/iptv_if.sv]
// iptv_char_if and iptv_kind_if: valid/ready channels for text characters
// and for the verdict. No dependencies.
interface iptv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface iptv_kind_if;
    logic       valid;
    logic       ready;
    logic [1:0] ip_kind;

    modport source (output valid, output ip_kind, input ready);
    modport sink   (input valid, input ip_kind, output ready);
endinterface

[rtl/iptv_queue.sv]
// iptv_queue: small fifo of classified characters between front and back.
// Depends on iptv_pkg.
module iptv_queue
    import iptv_pkg::*;
#(
    parameter int unsigned DEPTH = IPTV_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_iptv_cls i_push_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_nonempty,
    output t_iptv_cls o_head
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_iptv_cls       r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push, w_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_nonempty;

    // pointer and count updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end
endmodule

[rtl/iptv_front.sv]
// iptv_front: accepts characters and classifies them for the back end.
// Depends on iptv_pkg and iptv_char_if.
module iptv_front
    import iptv_pkg::*;
(
    iptv_char_if.sink  i_char,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_iptv_cls  o_push_data
);
    // accept whenever the queue has room
    assign i_char.ready = !i_queue_full;
    assign o_push       = i_char.valid && !i_queue_full;
    assign o_push_data  = iptv_classify(i_char.char_code, i_char.last_char);
endmodule

[rtl/iptv_back.sv]
// iptv_back: runs the dotted-decimal and colon-hex checks on classified characters
// and holds the verdict in an output register. Depends on iptv_pkg and iptv_kind_if.
module iptv_back
    import iptv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nonempty,
    input  t_iptv_cls   i_head,
    output logic        o_pop,
    iptv_kind_if.source o_kind
);
    localparam logic [2:0]  DEC_CNT_SAT = 3'd7;
    localparam logic [3:0]  HEX_CNT_SAT = 4'd15;
    localparam logic [2:0]  DEC_CNT_END = 3'(DEC_SECTIONS - 1);
    localparam logic [3:0]  HEX_CNT_END = 4'(HEX_SECTIONS - 1);
    localparam logic [12:0] DEC_LIM     = 13'(DEC_MAX);
    localparam logic [20:0] HEX_LIM     = 21'(HEX_MAX);
    localparam logic [12:0] DEC_MUL     = 13'(DEC_BASE);

    logic        r_seen_dot, n_seen_dot;
    logic        r_seen_colon, n_seen_colon;
    logic [2:0]  r_dec_cnt, n_dec_cnt;
    logic [8:0]  r_dec_val, n_dec_val;
    logic        r_dec_ne, n_dec_ne;
    logic        r_dec_ok, n_dec_ok;
    logic [3:0]  r_hex_cnt, n_hex_cnt;
    logic [16:0] r_hex_val, n_hex_val;
    logic        r_hex_ne, n_hex_ne;
    logic        r_hex_ok, n_hex_ok;
    logic        r_out_valid, n_out_valid;
    t_ip_kind    r_kind, n_kind;

    logic [12:0] w_dec_sum;
    logic [20:0] w_hex_sum;
    t_ip_kind    w_verdict;

    // take an item unless the verdict register is stalled
    assign o_pop = i_nonempty && (!r_out_valid || o_kind.ready);

    assign w_dec_sum = {4'd0, r_dec_val} * DEC_MUL + {9'd0, i_head.digit};
    assign w_hex_sum = {r_hex_val, 4'd0} + {17'd0, i_head.digit};

    // decimal check
    always_comb begin
        n_dec_cnt = r_dec_cnt;
        n_dec_val = r_dec_val;
        n_dec_ne  = r_dec_ne;
        n_dec_ok  = r_dec_ok;
        if (i_head.is_dot) begin
            if (!r_dec_ne) n_dec_ok = 1'b0;
            if (r_dec_cnt != DEC_CNT_SAT) n_dec_cnt = r_dec_cnt + 1'b1;
            if (n_dec_cnt > DEC_CNT_END) n_dec_ok = 1'b0;
            n_dec_val = '0;
            n_dec_ne  = 1'b0;
        end else if (i_head.is_dec) begin
            if (w_dec_sum > DEC_LIM) begin
                n_dec_val = 9'(DEC_MAX + 1);
                n_dec_ok  = 1'b0;
            end else begin
                n_dec_val = w_dec_sum[8:0];
            end
            n_dec_ne = 1'b1;
        end else begin
            n_dec_ok = 1'b0;
        end
    end

    // hex check
    always_comb begin
        n_hex_cnt = r_hex_cnt;
        n_hex_val = r_hex_val;
        n_hex_ne  = r_hex_ne;
        n_hex_ok  = r_hex_ok;
        if (i_head.is_colon) begin
            if (!r_hex_ne) n_hex_ok = 1'b0;
            if (r_hex_cnt != HEX_CNT_SAT) n_hex_cnt = r_hex_cnt + 1'b1;
            if (n_hex_cnt > HEX_CNT_END) n_hex_ok = 1'b0;
            n_hex_val = '0;
            n_hex_ne  = 1'b0;
        end else if (i_head.is_hex) begin
            if (w_hex_sum > HEX_LIM) begin
                n_hex_val = 17'(HEX_MAX + 1);
                n_hex_ok  = 1'b0;
            end else begin
                n_hex_val = w_hex_sum[16:0];
            end
            n_hex_ne = 1'b1;
        end else begin
            n_hex_ok = 1'b0;
        end
    end

    // separators seen and the verdict on the updated state
    always_comb begin
        n_seen_dot   = r_seen_dot || i_head.is_dot;
        n_seen_colon = r_seen_colon || i_head.is_colon;
        if (n_seen_dot) begin
            w_verdict = (n_dec_ok && n_dec_ne && n_dec_cnt == DEC_CNT_END) ?
                        KIND_V4 : KIND_UNKNOWN;
        end else if (n_seen_colon) begin
            w_verdict = (n_hex_ok && n_hex_ne && n_hex_cnt == HEX_CNT_END) ?
                        KIND_V6 : KIND_UNKNOWN;
        end else begin
            w_verdict = KIND_UNKNOWN;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        if (r_out_valid && o_kind.ready) n_out_valid = 1'b0;
        if (o_pop && i_head.last) begin
            n_out_valid = 1'b1;
            n_kind      = w_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_head.last)) begin
            r_seen_dot   <= 1'b0;
            r_seen_colon <= 1'b0;
            r_dec_cnt    <= '0;
            r_dec_val    <= '0;
            r_dec_ne     <= 1'b0;
            r_dec_ok     <= 1'b1;
            r_hex_cnt    <= '0;
            r_hex_val    <= '0;
            r_hex_ne     <= 1'b0;
            r_hex_ok     <= 1'b1;
        end else if (o_pop) begin
            r_seen_dot   <= n_seen_dot;
            r_seen_colon <= n_seen_colon;
            r_dec_cnt    <= n_dec_cnt;
            r_dec_val    <= n_dec_val;
            r_dec_ne     <= n_dec_ne;
            r_dec_ok     <= n_dec_ok;
            r_hex_cnt    <= n_hex_cnt;
            r_hex_val    <= n_hex_val;
            r_hex_ne     <= n_hex_ne;
            r_hex_ok     <= n_hex_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind.valid   = r_out_valid;
    assign o_kind.ip_kind = r_kind;
endmodule

[rtl/ip_address_text_validator_top.sv]
// A verdict reaches the verdict register after its last character has been
// written into the queue storage and then popped by the back end.
// Throughput: one character per cycle while the verdict is not stalled; the
// queue absorbs output stalls up to its depth.
// Reset: synchronous active low; clears queue, checks and the verdict valid flag.
// ip_address_text_validator_top: front, queue and back. Depends on iptv_pkg, iptv_if.
module ip_address_text_validator_top
    import iptv_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = IPTV_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iptv_char_if.sink   i_char,
    iptv_kind_if.source o_kind
);
    logic      w_full, w_push, w_pop, w_nonempty;
    t_iptv_cls w_push_data, w_head;

    // classify incoming characters
    iptv_front u_front (
        .i_char       (i_char),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // decoupling queue
    iptv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_nonempty  (w_nonempty),
        .o_head      (w_head)
    );

    // run the checks and give the verdict
    iptv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_kind     (o_kind)
    );
endmodule

[rtl/iptv_checker.sv]
// iptv_checker: port-level assertions for the validator top level, and the
// bind that attaches it. Depends on iptv_pkg and iptv_if.
module iptv_checker
    import iptv_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_char_ready,
    input logic       i_kind_valid,
    input logic       i_kind_ready,
    input logic [1:0] i_kind
);
    // no verdict right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        (!$past(i_rst_n) && i_rst_n) |-> !i_kind_valid)
        else $error("verdict valid right after reset");

    // verdict code is always a defined kind
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_kind_valid |-> (i_kind == KIND_V4 || i_kind == KIND_V6 ||
                          i_kind == KIND_UNKNOWN))
        else $error("undefined verdict code");

    // input back-pressure only follows a stalled verdict
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_char_ready && $past(i_rst_n)) |-> $past(i_kind_valid && !i_kind_ready))
        else $error("input stalled without output stall");

    // stalled verdict holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_kind_valid && !i_kind_ready) |=> (i_kind_valid && $stable(i_kind)))
        else $error("stalled verdict changed");
endmodule

bind ip_address_text_validator_top iptv_checker u_iptv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_char_ready (i_char.ready),
    .i_kind_valid (o_kind.valid),
    .i_kind_ready (o_kind.ready),
    .i_kind       (o_kind.ip_kind)
);
